FILE: rtl/tew_pkg.sv
package tew_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int NumRegs  = 8;
  localparam int AddrBits = 5;

  localparam logic [WordBits-1:0] WMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic [WordBits-1:0] WMin = {1'b1, {(WordBits-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_COLOR_GX = 3'd0,
    REG_COLOR_GY = 3'd1,
    REG_U_GX     = 3'd2,
    REG_U_GY     = 3'd3,
    REG_V_GX     = 3'd4,
    REG_V_GY     = 3'd5,
    REG_INVZ_GX  = 3'd6,
    REG_INVZ_GY  = 3'd7
  } reg_idx_t;

  localparam logic KIND_SETUP = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] base_color;
    logic signed [31:0] base_u;
    logic signed [31:0] base_v;
    logic signed [31:0] base_invz;
    logic signed [31:0] base_depth;
    logic signed [31:0] depth_grad_x;
    logic signed [31:0] depth_grad_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] edge_x;
    logic signed [31:0] edge_color;
    logic signed [31:0] edge_u;
    logic signed [31:0] edge_v;
    logic signed [31:0] edge_invz;
    logic signed [31:0] edge_depth;
    logic signed [15:0] first_row;
    logic signed [15:0] last_row;
    logic               degenerate;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_XMUL,
    ST_XPRE,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } be_state_t;

  // Saturate a 34-bit signed sum to the word range.
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd2147483647) r = WMax;
    else if (v < -34'sd2147483648) r = WMin;
    else r = v[31:0];
    return r;
  endfunction

  // Fixed multiply: floor((a*b) >> FracBits), saturated.
  function automatic logic [31:0] fxmul(input logic signed [31:0] a,
                                        input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] q;
    logic [31:0] r;
    p = a * b;
    q = p >>> FracBits;
    if (q > 64'sd2147483647) r = WMax;
    else if (q < -64'sd2147483648) r = WMin;
    else r = q[31:0];
    return r;
  endfunction

  function automatic logic [15:0] ceil_row(input logic signed [31:0] y);
    logic signed [32:0] t;
    logic signed [16:0] r;
    t = {y[31], y} + 33'sd65535;
    r = 17'(t >>> FracBits);
    if (r > 17'sd32767) return 16'h7fff;
    return r[15:0];
  endfunction

endpackage

FILE: rtl/tew_divider.sv
module tew_divider
  import tew_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] dividend,
  input  logic signed [32:0] divisor,
  output logic               done,
  output logic [31:0]        quotient
);

  // Restoring division of |dx|<<16 by |dy|, one quotient bit per cycle.
  logic [48:0] num;
  logic [32:0] den;
  logic [49:0] rem;
  logic [48:0] quo;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic [49:0] trial;
  logic [49:0] shifted;
  logic signed [50:0] sq;

  always_comb begin
    shifted = {rem[48:0], num[48]};
    trial   = shifted - {17'd0, den};
    sq      = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd49;
        num  <= {(dividend[32] ? 33'(-dividend) : dividend), 16'd0};
        den  <= divisor[32] ? 33'(-divisor) : divisor;
        neg  <= dividend[32] ^ divisor[32];
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        num <= {num[47:0], 1'b0};
        if (!trial[49]) begin
          rem <= trial;
          quo <= {quo[47:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[47:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (sq > 51'sd2147483647) quotient = WMax;
    else if (sq < -51'sd2147483648) quotient = WMin;
    else quotient = sq[31:0];
  end

endmodule

FILE: rtl/tew_front.sv
module tew_front
  import tew_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_pop,
  output in_item_t q_item
);

  // Two-entry queue between intake and the back end.
  in_item_t   mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/tew_back.sv
module tew_back
  import tew_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  in_item_t    q_item,
  input  logic [31:0] regs [NumRegs],
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  be_state_t st, st_next;
  in_item_t  it;
  logic [31:0] cur [6];
  logic [31:0] stp [6];
  logic [31:0] gx [5];
  logic [31:0] gy [5];
  logic [31:0] base [5];
  logic [31:0] m_y [5];
  logic [31:0] m_x [5];
  logic [31:0] m_s [5];
  logic [15:0] first_row;
  logic [15:0] last_row;
  logic        degen;
  logic [31:0] ypre;
  logic [31:0] xpre;
  logic [31:0] x_adv;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;
  logic        take;

  assign take = q_valid && (st == ST_IDLE);
  assign q_pop = take;

  // Prestep of x along y, the slope times the fractional row offset.
  assign x_adv = fxmul(ypre, stp[5]);

  tew_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({it.end_x[31], it.end_x} - {it.start_x[31], it.start_x}),
    .divisor({it.end_y[31], it.end_y} - {it.start_y[31], it.start_y}),
    .done(div_done), .quotient(div_q)
  );

  always_comb begin
    gx[0] = regs[REG_COLOR_GX]; gy[0] = regs[REG_COLOR_GY]; base[0] = it.base_color;
    gx[1] = regs[REG_U_GX];     gy[1] = regs[REG_U_GY];     base[1] = it.base_u;
    gx[2] = regs[REG_V_GX];     gy[2] = regs[REG_V_GY];     base[2] = it.base_v;
    gx[3] = regs[REG_INVZ_GX];  gy[3] = regs[REG_INVZ_GY];  base[3] = it.base_invz;
    gx[4] = it.depth_grad_x;    gy[4] = it.depth_grad_y;    base[4] = it.base_depth;
  end

  always_comb begin
    st_next   = st;
    div_start = 1'b0;
    unique case (st)
      ST_IDLE: if (take) begin
        st_next = (q_item.kind == KIND_STEP) ? ST_SUM : ST_DIV;
      end
      ST_DIV: st_next = ST_XMUL;
      // Wait here until the divider finishes; a flat edge does not wait.
      ST_XMUL: if (degen || div_done) st_next = ST_XPRE;
      ST_XPRE: st_next = ST_MUL;
      ST_MUL: st_next = ST_SUM;
      ST_SUM: st_next = ST_OUT;
      ST_OUT: if (!out_stall) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
    if (st == ST_DIV && it.end_y != it.start_y) div_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      degen <= 1'b0;
      first_row <= '0;
      last_row <= '0;
      for (int i = 0; i < 6; i++) begin
        cur[i] <= '0;
        stp[i] <= '0;
      end
    end else begin
      unique case (st)
        ST_IDLE: if (take) it <= q_item;
        ST_DIV: begin
          first_row <= ceil_row(it.start_y);
          last_row  <= ceil_row(it.end_y);
          degen     <= (it.end_y == it.start_y);
          ypre      <= {16'd0, 16'(-it.start_y[15:0])};
          stp[5]    <= '0;
        end
        ST_XMUL: begin
          if (div_done) stp[5] <= div_q;
        end
        default: ;
      endcase
      if (st == ST_XPRE) begin
        cur[5] <= sat34({{2{it.start_x[31]}}, it.start_x} + {{2{x_adv[31]}}, x_adv});
      end
      if (st == ST_MUL) begin
        xpre <= sat34({{2{cur[5][31]}}, cur[5]} - {{2{it.start_x[31]}}, it.start_x});
        for (int i = 0; i < 5; i++) begin
          m_y[i] <= fxmul(gy[i], ypre);
          m_s[i] <= fxmul(gx[i], stp[5]);
        end
      end
      if (st == ST_SUM) begin
        if (it.kind == KIND_STEP) begin
          for (int i = 0; i < 6; i++)
            cur[i] <= sat34({{2{cur[i][31]}}, cur[i]} + {{2{stp[i][31]}}, stp[i]});
        end else begin
          for (int i = 0; i < 5; i++) begin
            m_x[i] <= fxmul(gx[i], xpre);
            stp[i] <= degen ? '0 :
                      sat34({{2{gy[i][31]}}, gy[i]} + {{2{m_s[i][31]}}, m_s[i]});
          end
        end
      end
      if (st == ST_OUT && it.kind == KIND_SETUP && !out_stall) begin
        for (int i = 0; i < 5; i++)
          cur[i] <= sat34({{2{base[i][31]}}, base[i]} + {{2{m_y[i][31]}}, m_y[i]} +
                          {{2{m_x[i][31]}}, m_x[i]});
      end
      st <= st_next;
    end
  end

  // Setup results are summed as they leave; base+gy*ypre+gx*xpre.
  logic [31:0] res [5];
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if (it.kind == KIND_SETUP)
        res[i] = sat34({{2{base[i][31]}}, base[i]} + {{2{m_y[i][31]}}, m_y[i]} +
                       {{2{m_x[i][31]}}, m_x[i]});
      else
        res[i] = cur[i];
    end
    out_valid = (st == ST_OUT);
    out_item.edge_x     = cur[5];
    out_item.edge_color = res[0];
    out_item.edge_u     = res[1];
    out_item.edge_v     = res[2];
    out_item.edge_invz  = res[3];
    out_item.edge_depth = res[4];
    out_item.first_row  = first_row;
    out_item.last_row   = last_row;
    out_item.degenerate = degen;
  end

endmodule

FILE: rtl/triangle_edge_walker_top.sv
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_stall  in_item (in_item_t)
// out       output     out_valid/out_stall out_item (out_item_t)
// cfg       input      APB write/read     gradient registers 0..7
//
// A step transfer passes the back end through pick up, sum and present.
// A setup transfer waits on the bit-serial divider, which forms dx/dy one
// quotient bit a cycle; a flat edge skips the divider.
// A two-entry queue takes input transfers while the back end works.
// Reset is synchronous on rst and clears the registers, state and running edge values.
// A stalled result stays in the output state until the transfer completes.
module triangle_edge_walker_top
  import tew_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0] regs [NumRegs];
  logic        q_valid;
  logic        q_pop;
  in_item_t    q_item;

  assign pready = 1'b1;
  // Byte address bits 4:2 pick the register; bits 1:0 are ignored.
  assign prdata = regs[paddr[4:2]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) regs[i] <= '0;
    end else if (psel && penable && pwrite) begin
      regs[paddr[4:2]] <= pwdata;
    end
  end

  tew_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  tew_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .regs(regs), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

endmodule

FILE: rtl/tew_checker.sv
module tew_checker
  import tew_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input changed");

endmodule

bind triangle_edge_walker_top tew_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
